@@ src/lru_pkg.sv @@
// ----------------------------------------------------------------------------
// lru_pkg
// Shared constants and structs for the LRU page replacement core: port
// widths, parameter defaults and the flag groups passed along the cell chain.
// ----------------------------------------------------------------------------
package lru_pkg;

  // parameter defaults
  localparam int MAX_SLOTS_DEF = 16;
  localparam int PAGE_BITS_DEF = 16;

  // fixed port widths
  localparam int CFG_W       = 5;
  localparam int SLOT_W      = 4;
  localparam int PORT_PAGE_W = 16;
  localparam int COUNT_W     = 16;

  // register reset value and counter ceiling
  localparam logic [CFG_W-1:0]   FRAMES_RESET = 5'd4;
  localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;

  // flags carried by the search wave from cell to cell
  typedef struct packed {
    logic hit;      // a matching frame has been seen
    logic empty;    // an empty active frame has been seen
    logic vic_set;  // a victim candidate has been taken
  } lru_flags_t;

  // update command broadcast to every cell
  typedef struct packed {
    logic en;     // apply the update this cycle
    logic hit;    // reference hit, otherwise a fault
    logic clear;  // end of string, wipe the table
  } lru_upd_t;

endpackage

@@ src/lru_cell.sv @@
// ----------------------------------------------------------------------------
// lru_cell
// One frame of the table: resident page, valid bit and recency rank, plus a
// stage of the search wave that folds this frame into the running result.
// ----------------------------------------------------------------------------
module lru_cell #(
  parameter int IDX       = 0,
  parameter int MAX_SLOTS = lru_pkg::MAX_SLOTS_DEF,
  parameter int PAGE_BITS = lru_pkg::PAGE_BITS_DEF,
  parameter int IW        = $clog2(MAX_SLOTS)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [PAGE_BITS-1:0] page,
  input  logic                 active,
  // search wave in
  input  lru_pkg::lru_flags_t  flags_in,
  input  logic [IW-1:0]        hit_idx_in,
  input  logic [IW-1:0]        hit_rank_in,
  input  logic [IW-1:0]        empty_idx_in,
  input  logic [IW-1:0]        vic_idx_in,
  input  logic [IW-1:0]        vic_rank_in,
  input  logic [PAGE_BITS-1:0] vic_page_in,
  // search wave out, registered
  output lru_pkg::lru_flags_t  flags_out,
  output logic [IW-1:0]        hit_idx_out,
  output logic [IW-1:0]        hit_rank_out,
  output logic [IW-1:0]        empty_idx_out,
  output logic [IW-1:0]        vic_idx_out,
  output logic [IW-1:0]        vic_rank_out,
  output logic [PAGE_BITS-1:0] vic_page_out,
  // update broadcast
  input  lru_pkg::lru_upd_t    upd,
  input  logic [IW-1:0]        upd_slot,
  input  logic [IW-1:0]        upd_rank
);
  import lru_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);
  localparam logic [IW-1:0] RANK_MAX = IW'(MAX_SLOTS - 1);

  logic [PAGE_BITS-1:0] frame_page;
  logic                 frame_valid;
  logic [IW-1:0]        rank;

  lru_flags_t           flags_next;
  logic [IW-1:0]        hit_idx_next;
  logic [IW-1:0]        hit_rank_next;
  logic [IW-1:0]        empty_idx_next;
  logic [IW-1:0]        vic_idx_next;
  logic [IW-1:0]        vic_rank_next;
  logic [PAGE_BITS-1:0] vic_page_next;

  logic                 frame_valid_next;
  logic [IW-1:0]        rank_next;
  logic                 load;
  logic                 age;
  logic                 is_slot;

  // fold this frame into the search result
  always_comb begin
    flags_next     = flags_in;
    hit_idx_next   = hit_idx_in;
    hit_rank_next  = hit_rank_in;
    empty_idx_next = empty_idx_in;
    vic_idx_next   = vic_idx_in;
    vic_rank_next  = vic_rank_in;
    vic_page_next  = vic_page_in;
    // lowest matching frame wins
    if (active && frame_valid && (frame_page == page) && !flags_in.hit) begin
      flags_next.hit = 1'b1;
      hit_idx_next   = MY_IDX;
      hit_rank_next  = rank;
    end
    // lowest empty frame
    if (active && !frame_valid && !flags_in.empty) begin
      flags_next.empty = 1'b1;
      empty_idx_next   = MY_IDX;
    end
    // oldest frame, lowest index among equal ranks
    if (active && (!flags_in.vic_set || (rank > vic_rank_in))) begin
      flags_next.vic_set = 1'b1;
      vic_idx_next       = MY_IDX;
      vic_rank_next      = rank;
      vic_page_next      = frame_page;
    end
  end

  // search stage register
  always_ff @(posedge clk) begin
    flags_out     <= flags_next;
    hit_idx_out   <= hit_idx_next;
    hit_rank_out  <= hit_rank_next;
    empty_idx_out <= empty_idx_next;
    vic_idx_out   <= vic_idx_next;
    vic_rank_out  <= vic_rank_next;
    vic_page_out  <= vic_page_next;
  end

  // next frame state for an update
  always_comb begin
    is_slot          = (upd_slot == MY_IDX);
    age              = active && frame_valid && (rank != RANK_MAX) &&
                       (!upd.hit || (rank < upd_rank));
    rank_next        = rank;
    frame_valid_next = frame_valid;
    load             = 1'b0;
    if (age) begin
      rank_next = rank + 1'b1;
    end
    if (is_slot) begin
      rank_next = '0;
      if (!upd.hit) begin
        frame_valid_next = 1'b1;
        load             = 1'b1;
      end
    end
    if (upd.clear) begin
      rank_next        = '0;
      frame_valid_next = 1'b0;
    end
  end

  // frame control state
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
      rank        <= '0;
    end else if (upd.en) begin
      frame_valid <= frame_valid_next;
      rank        <= rank_next;
    end
  end

  // resident page
  always_ff @(posedge clk) begin
    if (upd.en && load) begin
      frame_page <= page;
    end
  end

endmodule

@@ src/lru_chain.sv @@
// ----------------------------------------------------------------------------
// lru_chain
// Row of frame cells. Decodes which frames are active, seeds the search wave
// at the first cell and presents the wave leaving the last cell.
// ----------------------------------------------------------------------------
module lru_chain #(
  parameter int MAX_SLOTS = lru_pkg::MAX_SLOTS_DEF,
  parameter int PAGE_BITS = lru_pkg::PAGE_BITS_DEF,
  parameter int IW        = $clog2(MAX_SLOTS),
  parameter int CW        = $clog2(MAX_SLOTS + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [PAGE_BITS-1:0] page,
  input  logic [CW-1:0]        n_act,
  input  lru_pkg::lru_upd_t    upd,
  input  logic [IW-1:0]        upd_slot,
  input  logic [IW-1:0]        upd_rank,
  output lru_pkg::lru_flags_t  res_flags,
  output logic [IW-1:0]        res_hit_idx,
  output logic [IW-1:0]        res_hit_rank,
  output logic [IW-1:0]        res_empty_idx,
  output logic [IW-1:0]        res_vic_idx,
  output logic [PAGE_BITS-1:0] res_vic_page
);
  import lru_pkg::*;

  // wave links, entry i feeds cell i
  lru_flags_t           flags    [MAX_SLOTS+1];
  logic [IW-1:0]        hit_idx  [MAX_SLOTS+1];
  logic [IW-1:0]        hit_rank [MAX_SLOTS+1];
  logic [IW-1:0]        empty_idx[MAX_SLOTS+1];
  logic [IW-1:0]        vic_idx  [MAX_SLOTS+1];
  logic [IW-1:0]        vic_rank [MAX_SLOTS+1];
  logic [PAGE_BITS-1:0] vic_page [MAX_SLOTS+1];
  logic [MAX_SLOTS-1:0] active;

  // empty search state enters the first cell
  assign flags[0]     = '0;
  assign hit_idx[0]   = '0;
  assign hit_rank[0]  = '0;
  assign empty_idx[0] = '0;
  assign vic_idx[0]   = '0;
  assign vic_rank[0]  = '0;
  assign vic_page[0]  = '0;

  // only the lowest n_act frames take part
  always_comb begin
    for (int i = 0; i < MAX_SLOTS; i++) begin
      active[i] = (CW'(i) < n_act);
    end
  end

  for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
    lru_cell #(
      .IDX       (g),
      .MAX_SLOTS (MAX_SLOTS),
      .PAGE_BITS (PAGE_BITS),
      .IW        (IW)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .page          (page),
      .active        (active[g]),
      .flags_in      (flags[g]),
      .hit_idx_in    (hit_idx[g]),
      .hit_rank_in   (hit_rank[g]),
      .empty_idx_in  (empty_idx[g]),
      .vic_idx_in    (vic_idx[g]),
      .vic_rank_in   (vic_rank[g]),
      .vic_page_in   (vic_page[g]),
      .flags_out     (flags[g+1]),
      .hit_idx_out   (hit_idx[g+1]),
      .hit_rank_out  (hit_rank[g+1]),
      .empty_idx_out (empty_idx[g+1]),
      .vic_idx_out   (vic_idx[g+1]),
      .vic_rank_out  (vic_rank[g+1]),
      .vic_page_out  (vic_page[g+1]),
      .upd           (upd),
      .upd_slot      (upd_slot),
      .upd_rank      (upd_rank)
    );
  end

  // result leaving the last cell; hit rank is also needed by the update
  assign res_flags     = flags[MAX_SLOTS];
  assign res_hit_idx   = hit_idx[MAX_SLOTS];
  assign res_hit_rank  = hit_rank[MAX_SLOTS];
  assign res_empty_idx = empty_idx[MAX_SLOTS];
  assign res_vic_idx   = vic_idx[MAX_SLOTS];
  assign res_vic_page  = vic_page[MAX_SLOTS];

endmodule

@@ src/lru_page_replacement_core.sv @@
// ----------------------------------------------------------------------------
// lru_page_replacement_core
// Fully associative LRU page table. Each input item is one page reference;
// each result item reports hit or fault, the frame used, any evicted page and
// the running fault count of the current reference string.
//
// Input channel (in_valid/in_ready) carries page and last_ref. Output channel
// (out_valid/out_ready) carries one result item per input item. The config
// channel (cfg_valid/cfg_data) writes frames_in_use, always ready; write it
// only while no reference is in flight.
// Operation: a search wave runs down the row of MAX_SLOTS cells, one cell per
// cycle, then one update step applies the result to all frames at once. The
// result is loaded into the output register by that same update step.
// One item is in flight at a time; the next item may be accepted while the
// previous result still waits in the output register. If the receiver
// stalls, the next item is held before its update until that result is taken.
// Reset clears the table, the fault counter and sets frames_in_use to 4.
// An item with last_ref set clears the table and counter after its result.
// ----------------------------------------------------------------------------
module lru_page_replacement_core #(
  parameter int MAX_SLOTS = lru_pkg::MAX_SLOTS_DEF,
  parameter int PAGE_BITS = lru_pkg::PAGE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // reference items
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [lru_pkg::PORT_PAGE_W-1:0]   page,
  input  logic                              last_ref,
  // result items
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              fault,
  output logic [lru_pkg::SLOT_W-1:0]        slot,
  output logic                              evicted_valid,
  output logic [lru_pkg::PORT_PAGE_W-1:0]   evicted_page,
  output logic [lru_pkg::COUNT_W-1:0]       fault_total,
  output logic                              string_end,
  // configuration
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lru_pkg::CFG_W-1:0]         cfg_data
);
  import lru_pkg::*;

  localparam int IW = $clog2(MAX_SLOTS);
  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam logic [IW-1:0] SCAN_LAST = IW'(MAX_SLOTS - 1);

  // controller states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  logic [1:0]           state;
  logic [IW-1:0]        scan_cnt;
  logic [CFG_W-1:0]     frames_in_use;
  logic [CW-1:0]        n_act;
  logic [31:0]          cfg_wide;
  logic [PAGE_BITS-1:0] page_r;
  logic                 last_r;
  logic [COUNT_W-1:0]   fault_cnt;
  logic [COUNT_W-1:0]   fault_cnt_next;

  lru_flags_t           res_flags;
  logic [IW-1:0]        res_hit_idx;
  logic [IW-1:0]        res_empty_idx;
  logic [IW-1:0]        res_vic_idx;
  logic [PAGE_BITS-1:0] res_vic_page;
  logic [IW-1:0]        hit_rank;

  lru_upd_t             upd;
  logic [IW-1:0]        upd_slot;
  logic                 ev_valid;
  logic                 in_acc;
  logic                 out_free;

  assign in_ready  = (state == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;

  // frames_in_use register
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= FRAMES_RESET;
    end else if (cfg_valid) begin
      frames_in_use <= cfg_data;
    end
  end

  // active frame count, clamped to 1..MAX_SLOTS
  always_comb begin
    cfg_wide = 32'(frames_in_use);
    if (cfg_wide == 32'd0) begin
      n_act = CW'(1);
    end else if (cfg_wide > 32'(MAX_SLOTS)) begin
      n_act = CW'(MAX_SLOTS);
    end else begin
      n_act = CW'(cfg_wide);
    end
  end

  // held reference
  always_ff @(posedge clk) begin
    if (in_acc) begin
      page_r <= PAGE_BITS'(page);
      last_r <= last_ref;
    end
  end

  // controller
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      scan_cnt <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            state    <= S_SCAN;
            scan_cnt <= '0;
          end
        end
        S_SCAN: begin
          scan_cnt <= scan_cnt + 1'b1;
          if (scan_cnt == SCAN_LAST) begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // decision from the wave leaving the last cell
  always_comb begin
    ev_valid = 1'b0;
    if (res_flags.hit) begin
      upd_slot = res_hit_idx;
    end else if (res_flags.empty) begin
      upd_slot = res_empty_idx;
    end else begin
      upd_slot = res_vic_idx;
      ev_valid = 1'b1;
    end
    upd.en    = (state == S_UPD) && out_free;
    upd.hit   = res_flags.hit;
    upd.clear = last_r;
    fault_cnt_next = fault_cnt;
    if (!res_flags.hit && (fault_cnt != COUNT_MAX)) begin
      fault_cnt_next = fault_cnt + 1'b1;
    end
  end

  // the chain keeps the hit rank alongside the hit index
  lru_chain #(
    .MAX_SLOTS (MAX_SLOTS),
    .PAGE_BITS (PAGE_BITS),
    .IW        (IW),
    .CW        (CW)
  ) u_chain (
    .clk           (clk),
    .rst           (rst),
    .page          (page_r),
    .n_act         (n_act),
    .upd           (upd),
    .upd_slot      (upd_slot),
    .upd_rank      (hit_rank),
    .res_flags     (res_flags),
    .res_hit_idx   (res_hit_idx),
    .res_hit_rank  (hit_rank),
    .res_empty_idx (res_empty_idx),
    .res_vic_idx   (res_vic_idx),
    .res_vic_page  (res_vic_page)
  );

  // fault counter
  always_ff @(posedge clk) begin
    if (rst) begin
      fault_cnt <= '0;
    end else if (upd.en) begin
      fault_cnt <= last_r ? '0 : fault_cnt_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (upd.en) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd.en) begin
      fault         <= !res_flags.hit;
      slot          <= SLOT_W'(upd_slot);
      evicted_valid <= ev_valid;
      evicted_page  <= ev_valid ? PORT_PAGE_W'(res_vic_page) : '0;
      fault_total   <= fault_cnt_next;
      string_end    <= last_r;
    end
  end

  // a hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid && !fault |-> !evicted_valid)
    else $error("eviction reported on a hit");

  // evicted page reads zero when nothing was evicted
  a_evict_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !evicted_valid |-> evicted_page == '0)
    else $error("evicted page not zero without eviction");

  // a fault result always carries a non-zero total
  a_fault_total: assert property (@(posedge clk) disable iff (rst)
    out_valid && fault |-> fault_total != '0)
    else $error("fault reported with zero total");

  // the counter steps by at most one, or clears at string end
  a_cnt_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (fault_cnt == $past(fault_cnt)) ||
                    (fault_cnt == $past(fault_cnt) + 1'b1) || (fault_cnt == '0))
    else $error("fault counter jumped");

endmodule
